// ----- src/i2p_pkg.sv -----
// Package for the infix to postfix converter.
// Holds the token and stack codes, the result and control structs, and small helpers.
// Depends on nothing; every other file but i2p_ram imports it.
package i2p_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    localparam int IDX_W    = 8;
    localparam int KIND_W   = 3;
    localparam int PREC_W   = 4;
    localparam int OKIND_W  = 2;
    localparam int STATUS_W = 2;

    localparam logic [KIND_W-1:0] TK_CONST = 3'd0;
    localparam logic [KIND_W-1:0] TK_VAR   = 3'd1;
    localparam logic [KIND_W-1:0] TK_FUNC  = 3'd2;
    localparam logic [KIND_W-1:0] TK_OPEN  = 3'd3;
    localparam logic [KIND_W-1:0] TK_CLOSE = 3'd4;
    localparam logic [KIND_W-1:0] TK_OPER  = 3'd5;

    localparam logic [OKIND_W-1:0] SK_PAREN = 2'd0;
    localparam logic [OKIND_W-1:0] SK_FUNC  = 2'd2;
    localparam logic [OKIND_W-1:0] SK_OPER  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK              = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNMATCHED_CLOSE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNMATCHED_OPEN  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW        = 2'd3;

    typedef struct packed {
        logic               assoc;
        logic [PREC_W-1:0]  prec;
        logic [OKIND_W-1:0] kind;
        logic [IDX_W-1:0]   idx;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [IDX_W-1:0]    idx;
        logic [OKIND_W-1:0]  kind;
        logic                has_symbol;
        logic [STATUS_W-1:0] status;
        logic                last;
    } t_result;

    typedef struct packed {
        logic    emit;
        logic    flush;
        logic    mark_last;
        logic    marker;
        t_result res;
    } t_ob_req;

    typedef struct packed {
        logic can_emit;
        logic out_free;
    } t_ob_sts;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FUNCHK,
        S_WAIT,
        S_DRAIN,
        S_FINISH
    } t_state;

    function automatic t_result mk_sym(input logic [IDX_W-1:0] idx,
                                       input logic [OKIND_W-1:0] kind);
        t_result r;
        r.idx        = idx;
        r.kind       = kind;
        r.has_symbol = 1'b1;
        r.status     = ST_OK;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic t_result mk_err(input logic [IDX_W-1:0] idx,
                                       input logic [STATUS_W-1:0] status);
        t_result r;
        r.idx        = idx;
        r.kind       = '0;
        r.has_symbol = 1'b0;
        r.status     = status;
        r.last       = 1'b1;
        return r;
    endfunction

endpackage

// ----- src/i2p_if.sv -----
// Handshake interfaces for the token input channel and the result output channel.
// Depends on i2p_pkg for the field widths.
interface i2p_tok_if;
    import i2p_pkg::*;

    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  token_index;
    logic [KIND_W-1:0] token_kind;
    logic [PREC_W-1:0] precedence;
    logic              left_assoc;
    logic              end_of_expr;

    modport source (output valid, token_index, token_kind, precedence, left_assoc,
                    end_of_expr, input ready);
    modport sink (input valid, token_index, token_kind, precedence, left_assoc,
                  end_of_expr, output ready);
endinterface

interface i2p_res_if;
    import i2p_pkg::*;

    logic                valid;
    logic                ready;
    logic [IDX_W-1:0]    out_index;
    logic [OKIND_W-1:0]  out_kind;
    logic                has_symbol;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, out_index, out_kind, has_symbol, status, last,
                    input ready);
    modport sink (input valid, out_index, out_kind, has_symbol, status, last,
                  output ready);
endinterface

// ----- src/i2p_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// A read of the address being written returns the old contents. No dependencies.
module i2p_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/i2p_obuf.sv -----
// Result buffer: one held-back result and one output register towards the sink.
// The held-back result lets the last flag be set once the end of an expression is known.
// Depends on i2p_pkg and i2p_if.
module i2p_obuf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  i2p_pkg::t_ob_req i_req,
    output i2p_pkg::t_ob_sts o_sts,
    i2p_res_if.source        o_res
);
    import i2p_pkg::*;

    logic    r_pend_v, n_pend_v;
    t_result r_pend, n_pend;
    logic    r_out_v, n_out_v;
    t_result r_out, n_out;
    logic    w_out_free;

    assign w_out_free     = !r_out_v || o_res.ready;
    assign o_sts.out_free = w_out_free;
    assign o_sts.can_emit = !r_pend_v || w_out_free;

    always_comb begin
        n_out_v  = r_out_v && !o_res.ready;
        n_out    = r_out;
        n_pend_v = r_pend_v;
        n_pend   = r_pend;
        if (i_req.emit) begin
            if (r_pend_v) begin
                n_out_v = 1'b1;
                n_out   = r_pend;
            end
            n_pend_v = 1'b1;
            n_pend   = i_req.res;
        end else if (i_req.flush) begin
            if (r_pend_v) begin
                n_out_v    = 1'b1;
                n_out      = r_pend;
                n_out.last = r_pend.last | i_req.mark_last;
                n_pend_v   = 1'b0;
            end else if (i_req.marker) begin
                n_out_v = 1'b1;
                n_out   = i_req.res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_res.valid      = r_out_v;
    assign o_res.out_index  = r_out.idx;
    assign o_res.out_kind   = r_out.kind;
    assign o_res.has_symbol = r_out.has_symbol;
    assign o_res.status     = r_out.status;
    assign o_res.last       = r_out.last;
endmodule

// ----- src/i2p_seq.sv -----
// Sequencer of the converter: token register, stack pointer and the compare unit
// that decides each push and pop, one entry per cycle while results can be taken.
// Depends on i2p_pkg and i2p_if; drives the stack RAM and the result buffer.
module i2p_seq #(
    parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    i2p_tok_if.sink                        i_tok,
    output i2p_pkg::t_ob_req               o_req,
    input  i2p_pkg::t_ob_sts               i_sts,
    output logic                           o_we,
    output logic [$clog2(STACK_DEPTH)-1:0] o_waddr,
    output i2p_pkg::t_entry                o_wdata,
    output logic [$clog2(STACK_DEPTH)-1:0] o_raddr,
    input  i2p_pkg::t_entry                i_rdata
);
    import i2p_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_disc, n_disc;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [KIND_W-1:0] r_kind, n_kind;
    logic [PREC_W-1:0] r_prec, n_prec;
    logic              r_assoc, n_assoc;
    logic              r_end, n_end;

    logic          w_accept;
    logic          w_empty;
    logic          w_full;
    logic          w_top_paren;
    logic          w_top_func;
    logic          w_oper_pops;
    logic [CW-1:0] w_cnt_m1;
    logic [CW-1:0] w_n_cnt_m1;
    t_state        w_after;

    assign i_tok.ready = (r_state == S_IDLE);
    assign w_accept    = i_tok.valid && i_tok.ready;
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == FULL);
    assign w_cnt_m1    = r_count - CW'(1);
    assign w_top_paren = (i_rdata.kind == SK_PAREN);
    assign w_top_func  = (i_rdata.kind == SK_FUNC);
    assign w_oper_pops = !w_empty && !w_top_paren &&
                         (w_top_func || (i_rdata.prec > r_prec) ||
                          ((i_rdata.prec == r_prec) && r_assoc));
    assign w_after     = r_end ? S_DRAIN : S_FINISH;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept && !r_disc) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_kind)
                    TK_CONST, TK_VAR: begin
                        if (i_sts.can_emit) begin
                            n_state = w_after;
                        end
                    end
                    TK_FUNC, TK_OPEN: begin
                        if (w_full) begin
                            if (i_sts.can_emit) begin
                                n_state = S_FINISH;
                            end
                        end else begin
                            n_state = r_end ? S_WAIT : S_FINISH;
                        end
                    end
                    TK_CLOSE: begin
                        if (i_sts.can_emit) begin
                            if (w_empty) begin
                                n_state = S_FINISH;
                            end else if (w_top_paren) begin
                                n_state = S_FUNCHK;
                            end
                        end
                    end
                    TK_OPER: begin
                        if (!w_oper_pops) begin
                            if (w_full) begin
                                if (i_sts.can_emit) begin
                                    n_state = S_FINISH;
                                end
                            end else begin
                                n_state = r_end ? S_WAIT : S_FINISH;
                            end
                        end
                    end
                    default: begin
                        n_state = w_after;
                    end
                endcase
            end
            S_FUNCHK: begin
                if (!(!w_empty && w_top_func) || i_sts.can_emit) begin
                    n_state = w_after;
                end
            end
            S_WAIT: begin
                n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (w_empty) begin
                    n_state = S_FINISH;
                end else if (i_sts.can_emit && w_top_paren) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_req         = '0;
        o_req.res     = mk_err('0, ST_OK);
        n_count       = r_count;
        n_disc        = r_disc;
        n_idx         = r_idx;
        n_kind        = r_kind;
        n_prec        = r_prec;
        n_assoc       = r_assoc;
        n_end         = r_end;
        o_we          = 1'b0;
        o_wdata.idx   = r_idx;
        o_wdata.kind  = SK_OPER;
        o_wdata.prec  = r_prec;
        o_wdata.assoc = r_assoc;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_idx   = i_tok.token_index;
                    n_kind  = i_tok.token_kind;
                    n_prec  = i_tok.precedence;
                    n_assoc = i_tok.left_assoc;
                    n_end   = i_tok.end_of_expr;
                    if (r_disc && i_tok.end_of_expr) begin
                        n_disc  = 1'b0;
                        n_count = '0;
                    end
                end
            end
            S_EXEC: begin
                case (r_kind)
                    TK_CONST, TK_VAR: begin
                        if (i_sts.can_emit) begin
                            o_req.emit = 1'b1;
                            o_req.res  = mk_sym(r_idx, r_kind[OKIND_W-1:0]);
                        end
                    end
                    TK_FUNC, TK_OPEN: begin
                        if (w_full) begin
                            if (i_sts.can_emit) begin
                                o_req.emit = 1'b1;
                                o_req.res  = mk_err(r_idx, ST_OVERFLOW);
                                n_count    = '0;
                                n_disc     = !r_end;
                            end
                        end else begin
                            o_we          = 1'b1;
                            o_wdata.kind  = (r_kind == TK_FUNC) ? SK_FUNC : SK_PAREN;
                            o_wdata.prec  = '0;
                            o_wdata.assoc = 1'b0;
                            n_count       = r_count + CW'(1);
                        end
                    end
                    TK_CLOSE: begin
                        if (i_sts.can_emit) begin
                            if (w_empty) begin
                                o_req.emit = 1'b1;
                                o_req.res  = mk_err(r_idx, ST_UNMATCHED_CLOSE);
                                n_count    = '0;
                                n_disc     = !r_end;
                            end else begin
                                n_count = w_cnt_m1;
                                if (!w_top_paren) begin
                                    o_req.emit = 1'b1;
                                    o_req.res  = mk_sym(i_rdata.idx, i_rdata.kind);
                                end
                            end
                        end
                    end
                    TK_OPER: begin
                        if (w_oper_pops) begin
                            if (i_sts.can_emit) begin
                                o_req.emit = 1'b1;
                                o_req.res  = mk_sym(i_rdata.idx, i_rdata.kind);
                                n_count    = w_cnt_m1;
                            end
                        end else if (w_full) begin
                            if (i_sts.can_emit) begin
                                o_req.emit = 1'b1;
                                o_req.res  = mk_err(r_idx, ST_OVERFLOW);
                                n_count    = '0;
                                n_disc     = !r_end;
                            end
                        end else begin
                            o_we    = 1'b1;
                            n_count = r_count + CW'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_FUNCHK: begin
                if (!w_empty && w_top_func && i_sts.can_emit) begin
                    o_req.emit = 1'b1;
                    o_req.res  = mk_sym(i_rdata.idx, i_rdata.kind);
                    n_count    = w_cnt_m1;
                end
            end
            S_WAIT: begin
            end
            S_DRAIN: begin
                if (!w_empty && i_sts.can_emit) begin
                    o_req.emit = 1'b1;
                    if (w_top_paren) begin
                        o_req.res = mk_err(i_rdata.idx, ST_UNMATCHED_OPEN);
                        n_count   = '0;
                        n_disc    = 1'b0;
                    end else begin
                        o_req.res = mk_sym(i_rdata.idx, i_rdata.kind);
                        n_count   = w_cnt_m1;
                    end
                end
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_req.flush     = 1'b1;
                    o_req.mark_last = r_end;
                    o_req.marker    = r_end;
                    o_req.res       = mk_err('0, ST_OK);
                end
                if (i_sts.out_free && r_end) begin
                    n_count = '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign w_n_cnt_m1 = n_count - CW'(1);
    assign o_raddr    = w_n_cnt_m1[AW-1:0];
    assign o_waddr    = r_count[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_disc  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_disc  <= n_disc;
        end
        r_idx   <= n_idx;
        r_kind  <= n_kind;
        r_prec  <= n_prec;
        r_assoc <= n_assoc;
        r_end   <= n_end;
    end
endmodule

// ----- src/infix_to_postfix_converter_top.sv -----
// The converter takes one classified token per transaction and returns the postfix
// symbols it releases, with an error result where the expression is malformed. A token
// passes through acceptance, an execute step and a finish step. An operator stays in
// its execute step while it pops entries. A closing parenthesis pops entries there down
// to and including the matching '(', then checks for a function below it. An end-flagged
// token that raises no error in its execute step then drains the stack, first through a
// wait step when it pushes. Each result also waits for the output register to be free.
// The operator stack is a single RAM with one registered read port, so the sequencer
// examines and pops one entry per cycle while the result buffer can accept. After an error,
// transactions are consumed without results up to and including the next end-flagged token.
// Depends on i2p_pkg, i2p_if, i2p_ram, i2p_obuf and i2p_seq.
module infix_to_postfix_converter_top #(
    parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    i2p_tok_if.sink   i_tok,
    i2p_res_if.source o_res
);
    import i2p_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);

    t_ob_req         w_req;
    t_ob_sts         w_sts;
    logic            w_we;
    logic [AW-1:0]   w_waddr;
    logic [AW-1:0]   w_raddr;
    t_entry          w_wdata;
    t_entry          w_rdata;
    logic [ENTRY_W-1:0] w_rdata_raw;

    assign w_rdata = t_entry'(w_rdata_raw);

    i2p_seq #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_seq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_tok  (i_tok),
        .o_req  (w_req),
        .i_sts  (w_sts),
        .o_we   (w_we),
        .o_waddr(w_waddr),
        .o_wdata(w_wdata),
        .o_raddr(w_raddr),
        .i_rdata(w_rdata)
    );

    i2p_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata_raw)
    );

    i2p_obuf u_obuf (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_sts  (w_sts),
        .o_res  (o_res)
    );
endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for infix_to_postfix_converter_top: drives classified tokens,
// predicts the postfix symbols and error results with a shadow operator stack, and checks them.
// Depends on i2p_pkg, i2p_if and the converter RTL.
module tb_top;
    import i2p_pkg::*;

    localparam int DEPTH         = STACK_DEPTH_DEF;
    localparam int SAW           = $clog2(DEPTH);
    localparam int RANDOM_TOKENS = 200;
    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 60;

    localparam logic [KIND_W-1:0] TK_SPARE_LO = 3'd6;
    localparam logic [KIND_W-1:0] TK_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [KIND_W-1:0] kind;
        logic [PREC_W-1:0] prec;
        logic              lassoc;
        logic              eoe;
    } t_token;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PATTERN
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    i2p_tok_if tok_if();
    i2p_res_if res_if();

    infix_to_postfix_converter_top #(
        .STACK_DEPTH(DEPTH)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok_if),
        .o_res   (res_if)
    );

    t_token           tokens_to_send[$];
    t_result          postfix_expected[$];
    t_entry           shadow_stack[DEPTH];
    int               shadow_depth    = 0;
    bit               shadow_discard  = 1'b0;
    logic [IDX_W-1:0] next_index      = '0;
    t_token           cur_token;
    t_result          got_result;
    t_result          want_result;
    int               burst_left      = 0;
    int               gap_left        = 0;
    int               idle_cycles     = 0;
    int               fail_count      = 0;
    int               tokens_total    = 0;
    int               tokens_accepted = 0;
    logic [7:0]       rx_phase        = '0;
    t_rx_mode         rx_mode         = RX_OPEN;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic note_result(input logic [IDX_W-1:0] idx, input logic [OKIND_W-1:0] kind,
                               input logic has, input logic [STATUS_W-1:0] status,
                               input logic last);
        t_result r;
        r.idx        = idx;
        r.kind       = kind;
        r.has_symbol = has;
        r.status     = status;
        r.last       = last;
        postfix_expected.push_back(r);
    endtask

    task automatic shunt_token(input t_token t);
        t_entry              ent;
        logic [STATUS_W-1:0] err;
        logic [IDX_W-1:0]    err_idx;
        int                  emitted;
        bit                  scanning;
        err     = ST_OK;
        err_idx = '0;
        emitted = 0;
        if (shadow_discard) begin
            if (t.eoe) begin
                shadow_discard = 1'b0;
                shadow_depth   = 0;
            end
            return;
        end
        case (t.kind)
            TK_CONST, TK_VAR: begin
                note_result(t.index, t.kind[OKIND_W-1:0], 1'b1, ST_OK, 1'b0);
                emitted++;
            end
            TK_FUNC, TK_OPEN: begin
                if (shadow_depth >= DEPTH) begin
                    err     = ST_OVERFLOW;
                    err_idx = t.index;
                end else begin
                    ent      = '0;
                    ent.idx  = t.index;
                    ent.kind = (t.kind == TK_FUNC) ? SK_FUNC : SK_PAREN;
                    shadow_stack[SAW'(shadow_depth)] = ent;
                    shadow_depth++;
                end
            end
            TK_CLOSE: begin
                scanning = 1'b1;
                while (scanning) begin
                    if (shadow_depth == 0) begin
                        err      = ST_UNMATCHED_CLOSE;
                        err_idx  = t.index;
                        scanning = 1'b0;
                    end else begin
                        shadow_depth--;
                        ent = shadow_stack[SAW'(shadow_depth)];
                        if (ent.kind == SK_PAREN) begin
                            if (shadow_depth > 0 &&
                                shadow_stack[SAW'(shadow_depth - 1)].kind == SK_FUNC) begin
                                shadow_depth--;
                                note_result(shadow_stack[SAW'(shadow_depth)].idx,
                                            shadow_stack[SAW'(shadow_depth)].kind,
                                            1'b1, ST_OK, 1'b0);
                                emitted++;
                            end
                            scanning = 1'b0;
                        end else begin
                            note_result(ent.idx, ent.kind, 1'b1, ST_OK, 1'b0);
                            emitted++;
                        end
                    end
                end
            end
            TK_OPER: begin
                scanning = 1'b1;
                while (scanning && shadow_depth > 0) begin
                    ent = shadow_stack[SAW'(shadow_depth - 1)];
                    if (ent.kind != SK_PAREN && (ent.kind == SK_FUNC || ent.prec > t.prec ||
                                                 (ent.prec == t.prec && t.lassoc))) begin
                        shadow_depth--;
                        note_result(ent.idx, ent.kind, 1'b1, ST_OK, 1'b0);
                        emitted++;
                    end else begin
                        scanning = 1'b0;
                    end
                end
                if (shadow_depth >= DEPTH) begin
                    err     = ST_OVERFLOW;
                    err_idx = t.index;
                end else begin
                    ent.idx   = t.index;
                    ent.kind  = SK_OPER;
                    ent.prec  = t.prec;
                    ent.assoc = t.lassoc;
                    shadow_stack[SAW'(shadow_depth)] = ent;
                    shadow_depth++;
                end
            end
            default: begin
            end
        endcase
        if (err == ST_OK && t.eoe) begin
            while (err == ST_OK && shadow_depth > 0) begin
                shadow_depth--;
                ent = shadow_stack[SAW'(shadow_depth)];
                if (ent.kind == SK_PAREN) begin
                    err     = ST_UNMATCHED_OPEN;
                    err_idx = ent.idx;
                end else begin
                    note_result(ent.idx, ent.kind, 1'b1, ST_OK, 1'b0);
                    emitted++;
                end
            end
        end
        if (err != ST_OK) begin
            note_result(err_idx, '0, 1'b0, err, 1'b1);
            shadow_depth   = 0;
            shadow_discard = !t.eoe;
        end else if (t.eoe) begin
            if (emitted > 0) begin
                postfix_expected[postfix_expected.size()-1].last = 1'b1;
            end else begin
                note_result('0, '0, 1'b0, ST_OK, 1'b1);
            end
            shadow_depth = 0;
        end
    endtask

    task automatic add_token(input logic [KIND_W-1:0] kind, input logic [PREC_W-1:0] prec,
                             input logic lassoc);
        t_token t;
        t.index  = next_index;
        t.kind   = kind;
        t.prec   = prec;
        t.lassoc = lassoc;
        t.eoe    = 1'b0;
        tokens_to_send.push_back(t);
        next_index++;
    endtask

    task automatic add_plain(input logic [KIND_W-1:0] kind);
        add_token(kind, PREC_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endtask

    task automatic add_operator();
        if ($urandom_range(0, 3) == 0) begin
            add_token(TK_OPER, PREC_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
        end else begin
            add_token(TK_OPER, PREC_W'($urandom_range(4, 6)), 1'($urandom_range(0, 1)));
        end
    endtask

    task automatic mark_end();
        tokens_to_send[tokens_to_send.size()-1].eoe = 1'b1;
    endtask

    task automatic build_wellformed(input bit mutate);
        int first;
        int count;
        int target;
        int opened;
        bit need_operand;
        bit going;
        first        = tokens_to_send.size();
        count        = 0;
        opened       = 0;
        target       = $urandom_range(1, 14);
        need_operand = 1'b1;
        going        = 1'b1;
        while (going) begin
            if (need_operand) begin
                if ($urandom_range(0, 5) <= 1 && opened < 5 && count < target) begin
                    if ($urandom_range(0, 1) == 0) begin
                        add_plain(TK_FUNC);
                        count++;
                    end
                    add_plain(TK_OPEN);
                    opened++;
                end else begin
                    add_plain(($urandom_range(0, 1) == 0) ? TK_CONST : TK_VAR);
                    need_operand = 1'b0;
                end
                count++;
            end else if (count >= target) begin
                if (opened > 0) begin
                    add_plain(TK_CLOSE);
                    opened--;
                end else begin
                    going = 1'b0;
                end
            end else begin
                if (opened > 0 && $urandom_range(0, 3) == 0) begin
                    add_plain(TK_CLOSE);
                    opened--;
                end else begin
                    add_operator();
                    need_operand = 1'b1;
                end
                count++;
            end
        end
        mark_end();
        if (mutate) begin
            tokens_to_send[$urandom_range(first, tokens_to_send.size()-1)].kind =
                KIND_W'($urandom_range(TK_CONST, TK_SPARE_HI));
        end
    endtask

    task automatic build_deep();
        int n;
        int closes;
        n = $urandom_range(DEPTH - 3, DEPTH + 2);
        for (int i = 0; i < n; i++) begin
            add_plain(($urandom_range(0, 2) == 0) ? TK_FUNC : TK_OPEN);
        end
        if ($urandom_range(0, 2) == 0) begin
            add_operator();
        end
        add_plain(TK_CONST);
        if ($urandom_range(0, 1) == 0) begin
            add_operator();
            add_plain(TK_VAR);
        end
        closes = $urandom_range(0, n);
        for (int i = 0; i < closes; i++) begin
            add_plain(TK_CLOSE);
        end
        mark_end();
    endtask

    task automatic build_noise();
        int n;
        t_token t;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) begin
            t.index  = IDX_W'($urandom_range(0, 255));
            t.kind   = KIND_W'($urandom_range(TK_CONST, TK_SPARE_HI));
            t.prec   = PREC_W'($urandom_range(0, 15));
            t.lassoc = 1'($urandom_range(0, 1));
            t.eoe    = ($urandom_range(0, 4) == 0);
            tokens_to_send.push_back(t);
        end
        mark_end();
    endtask

    task automatic build_directed();
        // Lowest and highest precedence, right-associative chain at equal precedence.
        next_index = 8'h00;
        add_token(TK_CONST, 4'd9, 1'b0);
        add_token(TK_OPER, 4'd0, 1'b1);
        add_token(TK_VAR, 4'd0, 1'b1);
        add_token(TK_OPER, 4'd15, 1'b0);
        add_token(TK_CONST, 4'd0, 1'b0);
        add_token(TK_OPER, 4'd15, 1'b0);
        add_token(TK_CONST, 4'd15, 1'b1);
        mark_end();
        // A function call whose closing parenthesis releases the function.
        next_index = 8'hFE;
        add_token(TK_FUNC, 4'd15, 1'b1);
        add_token(TK_OPEN, 4'd0, 1'b0);
        add_token(TK_VAR, 4'd0, 1'b0);
        add_token(TK_CLOSE, 4'd0, 1'b0);
        add_token(TK_OPER, 4'd15, 1'b1);
        add_token(TK_CONST, 4'd0, 1'b0);
        mark_end();
        // An unmatched close on the end-flagged token, then an unmatched open.
        next_index = 8'hAA;
        add_token(TK_CLOSE, 4'd0, 1'b0);
        mark_end();
        next_index = 8'h55;
        add_token(TK_OPEN, 4'd0, 1'b0);
        add_token(TK_CONST, 4'd0, 1'b0);
        mark_end();
        // An unmatched close mid-expression, so the rest is discarded.
        add_token(TK_CLOSE, 4'd0, 1'b0);
        add_token(TK_CONST, 4'd0, 1'b0);
        add_token(TK_OPER, 4'd3, 1'b1);
        add_token(TK_VAR, 4'd0, 1'b0);
        mark_end();
        // Undefined kinds, an empty expression end and an operator arriving on a function.
        add_token(TK_SPARE_LO, 4'd0, 1'b0);
        mark_end();
        add_token(TK_SPARE_HI, 4'd7, 1'b1);
        add_token(TK_CONST, 4'd0, 1'b0);
        mark_end();
        add_token(TK_FUNC, 4'd0, 1'b0);
        add_token(TK_OPER, 4'd0, 1'b0);
        add_token(TK_VAR, 4'd0, 1'b0);
        mark_end();
    endtask

    initial begin
        int directed_count;
        int pick;
        i_rst_n              = 1'b0;
        tok_if.valid         = 1'b0;
        tok_if.token_index   = '0;
        tok_if.token_kind    = '0;
        tok_if.precedence    = '0;
        tok_if.left_assoc    = 1'b0;
        tok_if.end_of_expr   = 1'b0;
        res_if.ready         = 1'b0;

        build_directed();
        directed_count = tokens_to_send.size();
        while (tokens_to_send.size() < directed_count + RANDOM_TOKENS) begin
            next_index = IDX_W'($urandom_range(0, 255));
            pick       = $urandom_range(0, 9);
            if (pick <= 6) begin
                build_wellformed(1'b0);
            end else if (pick == 7) begin
                build_deep();
            end else if (pick == 8) begin
                build_noise();
            end else begin
                build_wellformed(1'b1);
            end
        end
        tokens_total = tokens_to_send.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        while (tokens_accepted < tokens_total) @(posedge i_clk);
        while (postfix_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("** infix_to_postfix_converter_top: PASSED **");
        end else begin
            $display("** infix_to_postfix_converter_top: FAILED **");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tok_if.valid <= 1'b0;
        end else begin
            if (tok_if.valid && tok_if.ready) begin
                shunt_token(cur_token);
                tokens_accepted++;
            end
            if (!tok_if.valid || tok_if.ready) begin
                if (gap_left > 0 || tokens_to_send.size() == 0) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end
                    tok_if.valid <= 1'b0;
                end else begin
                    cur_token = tokens_to_send.pop_front();
                    tok_if.valid       <= 1'b1;
                    tok_if.token_index <= cur_token.index;
                    tok_if.token_kind  <= cur_token.kind;
                    tok_if.precedence  <= cur_token.prec;
                    tok_if.left_assoc  <= cur_token.lassoc;
                    tok_if.end_of_expr <= cur_token.eoe;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            rx_phase++;
            if (rx_phase[5:0] == '0) begin
                rx_mode = t_rx_mode'($urandom_range(RX_OPEN, RX_PATTERN));
            end
            case (rx_mode)
                RX_OPEN:   res_if.ready <= 1'b1;
                RX_COIN:   res_if.ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: res_if.ready <= (rx_phase[1:0] == 2'b11);
                default:   res_if.ready <= rx_phase[2] ^ rx_phase[4];
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            got_result.idx        = res_if.out_index;
            got_result.kind       = res_if.out_kind;
            got_result.has_symbol = res_if.has_symbol;
            got_result.status     = res_if.status;
            got_result.last       = res_if.last;
            if (postfix_expected.size() == 0) begin
                $error("unexpected result transaction: out_index %0d, status %0d",
                       got_result.idx, got_result.status);
                fail_count++;
            end else begin
                want_result = postfix_expected.pop_front();
                if (got_result.idx != want_result.idx) begin
                    $error("out_index: expected %0d, actual %0d", want_result.idx, got_result.idx);
                    fail_count++;
                end
                if (got_result.kind != want_result.kind) begin
                    $error("out_kind: expected %0d, actual %0d", want_result.kind,
                           got_result.kind);
                    fail_count++;
                end
                if (got_result.has_symbol != want_result.has_symbol) begin
                    $error("has_symbol: expected %0d, actual %0d", want_result.has_symbol,
                           got_result.has_symbol);
                    fail_count++;
                end
                if (got_result.status != want_result.status) begin
                    $error("status: expected %0d, actual %0d", want_result.status,
                           got_result.status);
                    fail_count++;
                end
                if (got_result.last != want_result.last) begin
                    $error("last: expected %0d, actual %0d", want_result.last, got_result.last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (tok_if.valid && tok_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** infix_to_postfix_converter_top: FAILED **");
                $finish;
            end
        end
    end

endmodule
